FILE: src/irdl_pkg.sv
// ----------------------------------------------------------------------------
// irdl_pkg
// Shared widths, constants, register indexes and lane handshake structs of
// the IR distance linearizer.
// ----------------------------------------------------------------------------
package irdl_pkg;

    localparam int RAW_W  = 16;
    localparam int CAL_W  = 16;
    localparam int DIST_W = 24;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;
    localparam int ADDR_W = IDX_W + 2;

    // |5*(n-f)| fits in 19 bits; 3*65536*n*f fits in 50 bits
    localparam int DEN_W  = 19;
    localparam int DIV_W  = 50;
    localparam int CNT_W  = $clog2(DIV_W);
    localparam int PROD_W = 2 * CAL_W;
    localparam int SUM_W  = DIV_W + 2;

    localparam logic signed [DIST_W-1:0] FAR_DIST = DIST_W'(655360);
    localparam logic signed [SUM_W-1:0]  SUM_MAX  = SUM_W'(2**(DIST_W-1) - 1);
    localparam logic signed [SUM_W-1:0]  SUM_MIN  = -SUM_MAX - SUM_W'(1);

    typedef enum logic [IDX_W-1:0] {
        REG_NEAR_LEFT   = 3'd0,
        REG_FAR_LEFT    = 3'd1,
        REG_NEAR_FRONT  = 3'd2,
        REG_FAR_FRONT   = 3'd3,
        REG_POWER_REQ   = 3'd4,
        REG_INSTALLED   = 3'd5
    } cfg_idx_t;

    localparam logic [CAL_W-1:0] NEAR_RESET = CAL_W'(3000);
    localparam logic [CAL_W-1:0] FAR_RESET  = CAL_W'(850);

    typedef struct packed {
        logic             start;
        logic             powered;
        logic [RAW_W-1:0] raw;
        logic [CAL_W-1:0] near;
        logic [CAL_W-1:0] far;
    } lane_req_t;

    typedef struct packed {
        logic                     done;
        logic                     fault;
        logic signed [DIST_W-1:0] distance;
    } lane_stat_t;

endpackage

FILE: src/irdl_if.sv
// ----------------------------------------------------------------------------
// irdl_if
// Valid/ready stream interfaces for raw sensor samples and distance results.
// ----------------------------------------------------------------------------
interface irdl_in_if;
    import irdl_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_left;
    logic [RAW_W-1:0] raw_front;

    modport source (output valid, raw_left, raw_front, input ready);
    modport sink   (input valid, raw_left, raw_front, output ready);
endinterface

interface irdl_out_if;
    import irdl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DIST_W-1:0] distance_left;
    logic signed [DIST_W-1:0] distance_front;
    logic                     fault_left;
    logic                     fault_front;

    modport source (output valid, distance_left, distance_front, fault_left, fault_front,
                    input ready);
    modport sink   (input valid, distance_left, distance_front, fault_left, fault_front,
                    output ready);
endinterface

FILE: src/irdl_div.sv
// ----------------------------------------------------------------------------
// irdl_div
// Unsigned restoring divider, one quotient bit per cycle, DIV_W steps.
// ----------------------------------------------------------------------------
module irdl_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [irdl_pkg::DIV_W-1:0] num,
    input  logic [irdl_pkg::DEN_W-1:0] den,
    output logic                       busy,
    output logic                       done,
    output logic [irdl_pkg::DIV_W-1:0] quot
);
    import irdl_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DIV_W-1:0] nq_reg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_next;

    always_comb
    begin
        shifted  = {rem_reg, nq_reg[DIV_W-1]};
        diff     = shifted - {1'b0, den_reg};
        ge       = (shifted >= {1'b0, den_reg});
        rem_next = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // shift quotient bits in from the right as numerator bits leave on the left
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg  <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            nq_reg  <= {nq_reg[DIV_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = nq_reg;

endmodule

FILE: src/irdl_lane.sv
// ----------------------------------------------------------------------------
// irdl_lane
// One sensor channel: coefficient divisions, inverse-law division by the raw
// reading, saturation and the held distance.
// ----------------------------------------------------------------------------
module irdl_lane (
    input  logic                   clk,
    input  logic                   rst_n,
    input  irdl_pkg::lane_req_t    req,
    input  logic                   ack,
    output irdl_pkg::lane_stat_t   stat
);
    import irdl_pkg::*;

    typedef enum logic [5:0] {
        L_IDLE  = 6'b000001,
        L_MUL   = 6'b000010,
        L_LOAD  = 6'b000100,
        L_DIVAB = 6'b001000,
        L_DIVR  = 6'b010000,
        L_DONE  = 6'b100000
    } lane_state_t;

    lane_state_t              state_reg;
    lane_state_t              state_next;
    logic [RAW_W-1:0]         raw_reg;
    logic [CAL_W-1:0]         near_reg;
    logic [CAL_W-1:0]         far_reg;
    logic [PROD_W-1:0]        nf_reg;
    logic                     neg_a_reg;
    logic                     neg_b_reg;
    logic signed [SUM_W-1:0]  aq_reg;
    logic signed [DIST_W-1:0] held_reg;
    logic                     fault_reg;

    logic                     fault_now;
    logic signed [CAL_W:0]    nf_diff;
    logic [CAL_W-1:0]         diff_mag;
    logic [DEN_W-1:0]         den_mag;
    logic signed [CAL_W+2:0]  a_term;
    logic [CAL_W+1:0]         a_mag;
    logic [PROD_W+1:0]        nf3;
    logic [DIV_W-1:0]         num_a;
    logic [DIV_W-1:0]         num_b;
    logic [DEN_W-1:0]         den_b;
    logic                     start_a;
    logic                     start_b;
    logic                     busy_a;
    logic                     busy_b;
    logic                     done_a;
    logic                     done_b;
    logic [DIV_W-1:0]         quot_a;
    logic [DIV_W-1:0]         quot_b;
    logic signed [SUM_W-1:0]  qa_ext;
    logic signed [SUM_W-1:0]  qb_ext;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DIST_W-1:0] sum_sat;

    assign fault_now = (req.near == req.far);

    // sign and magnitude of 5*(n-f) and (n-4f)*65536, 3*65536*n*f, divider operands and starts
    always_comb
    begin
        nf_diff  = $signed({1'b0, near_reg}) - $signed({1'b0, far_reg});
        diff_mag = nf_diff[CAL_W] ? CAL_W'(-nf_diff) : nf_diff[CAL_W-1:0];
        den_mag  = {1'b0, diff_mag, 2'b00} + {3'b000, diff_mag};
        a_term   = $signed({3'b000, near_reg}) - $signed({1'b0, far_reg, 2'b00});
        a_mag    = a_term[CAL_W+2] ? (CAL_W+2)'(-a_term) : a_term[CAL_W+1:0];
        nf3      = {1'b0, nf_reg, 1'b0} + {2'b00, nf_reg};
        num_a    = DIV_W'({a_mag, 16'h0000});
        num_b    = (state_reg == L_LOAD) ? {nf3, 16'h0000} : quot_b;
        den_b    = (state_reg == L_LOAD) ? den_mag : DEN_W'(raw_reg);
        start_a  = (state_reg == L_LOAD);
        start_b  = (state_reg == L_LOAD) || ((state_reg == L_DIVAB) && done_b);
    end

    irdl_div u_div_a (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_a),
        .num   (num_a),
        .den   (den_mag),
        .busy  (busy_a),
        .done  (done_a),
        .quot  (quot_a)
    );

    irdl_div u_div_b (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_b),
        .num   (num_b),
        .den   (den_b),
        .busy  (busy_b),
        .done  (done_b),
        .quot  (quot_b)
    );

    always_comb
    begin
        qa_ext  = $signed({{(SUM_W-DIV_W){1'b0}}, quot_a});
        qb_ext  = $signed({{(SUM_W-DIV_W){1'b0}}, quot_b});
        sum     = aq_reg + (neg_b_reg ? -qb_ext : qb_ext);
        if (sum > SUM_MAX)
            sum_sat = SUM_MAX[DIST_W-1:0];
        else if (sum < SUM_MIN)
            sum_sat = SUM_MIN[DIST_W-1:0];
        else
            sum_sat = sum[DIST_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            L_IDLE:
            begin
                if (req.start)
                begin
                    if (!req.powered || fault_now || (req.raw == '0))
                        state_next = L_DONE;
                    else
                        state_next = L_MUL;
                end
            end
            L_MUL:   state_next = L_LOAD;
            L_LOAD:  state_next = L_DIVAB;
            L_DIVAB: if (done_a) state_next = L_DIVR;
            L_DIVR:  if (done_b) state_next = L_DONE;
            L_DONE:  if (ack) state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            held_reg  <= '0;
            fault_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == L_IDLE) && req.start)
            begin
                fault_reg <= fault_now;
                if (!req.powered || fault_now)
                    held_reg <= FAR_DIST;
            end
            else if ((state_reg == L_DIVR) && done_b)
            begin
                held_reg <= sum_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == L_IDLE) && req.start)
        begin
            raw_reg  <= req.raw;
            near_reg <= req.near;
            far_reg  <= req.far;
        end
        if (state_reg == L_MUL)
            nf_reg <= near_reg * far_reg;
        if (state_reg == L_LOAD)
        begin
            neg_a_reg <= a_term[CAL_W+2] ^ nf_diff[CAL_W];
            neg_b_reg <= nf_diff[CAL_W];
        end
        if ((state_reg == L_DIVAB) && done_a)
            aq_reg <= neg_a_reg ? -qa_ext : qa_ext;
    end

    assign stat.done     = (state_reg == L_DONE);
    assign stat.fault    = fault_reg;
    assign stat.distance = held_reg;

    // both coefficient divisions run in lockstep
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == L_DIVAB) |-> (done_a == done_b))
        else $error("coefficient dividers out of step");

    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == L_DONE) |-> (!busy_a && !busy_b))
        else $error("lane reports done while a divider is busy");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> (state_reg == L_IDLE))
        else $error("lane started while busy");

endmodule

FILE: src/ir_distance_linearizer.sv
// ----------------------------------------------------------------------------
// ir_distance_linearizer
// Two-channel IR distance linearizer, d = A + B/raw with two-point
// calibration per sensor, signed Q8.16 meters.
// ----------------------------------------------------------------------------
// Usage:
//   sensor_in carries one transaction per sample: a raw reading for the left
//   and the front sensor. dist_out returns one transaction per sample with
//   both distances and the calibration fault flags.
//   Both channels run in their own lane side by side. A lane that computes
//   runs its setup states L_MUL and L_LOAD, then two passes of the 50-step
//   restoring divider (coefficients, then division by the raw reading); a
//   lane with power off, a calibration fault or a zero reading goes straight
//   to its done state. One sample is in flight at a time: the next is taken
//   only after both lane results are loaded into the result register. The
//   result register decouples the sides: the next sample is accepted while a
//   finished result waits; if the receiver stalls, that next result waits in
//   the lanes and sensor_in stays not ready. Reset loads the calibration
//   defaults, power off, held distances zero. The user writes registers over
//   the APB port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module ir_distance_linearizer (
    input  logic                        clk,
    input  logic                        rst_n,
    irdl_in_if.sink                     sensor_in,
    irdl_out_if.source                  dist_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [irdl_pkg::ADDR_W-1:0] paddr,
    input  logic [irdl_pkg::DATA_W-1:0] pwdata,
    output logic [irdl_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import irdl_pkg::*;

    typedef enum logic [1:0] {
        T_IDLE = 2'b01,
        T_BUSY = 2'b10
    } top_state_t;

    top_state_t               state_reg;
    logic [CAL_W-1:0]         near_left_reg;
    logic [CAL_W-1:0]         far_left_reg;
    logic [CAL_W-1:0]         near_front_reg;
    logic [CAL_W-1:0]         far_front_reg;
    logic                     power_req_reg;
    logic                     installed_reg;
    logic                     out_valid_reg;
    logic signed [DIST_W-1:0] dist_left_reg;
    logic signed [DIST_W-1:0] dist_front_reg;
    logic                     fault_left_reg;
    logic                     fault_front_reg;

    logic                     accept;
    logic                     load;
    logic                     powered;
    logic                     cfg_write;
    cfg_idx_t                 cfg_idx;
    lane_req_t                req_left;
    lane_req_t                req_front;
    lane_stat_t               stat_left;
    lane_stat_t               stat_front;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = cfg_idx_t'(paddr[ADDR_W-1:2]);
    assign powered   = power_req_reg && installed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_left_reg  <= NEAR_RESET;
            far_left_reg   <= FAR_RESET;
            near_front_reg <= NEAR_RESET;
            far_front_reg  <= FAR_RESET;
            power_req_reg  <= 1'b0;
            installed_reg  <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_NEAR_LEFT:  near_left_reg  <= pwdata[CAL_W-1:0];
                REG_FAR_LEFT:   far_left_reg   <= pwdata[CAL_W-1:0];
                REG_NEAR_FRONT: near_front_reg <= pwdata[CAL_W-1:0];
                REG_FAR_FRONT:  far_front_reg  <= pwdata[CAL_W-1:0];
                REG_POWER_REQ:  power_req_reg  <= pwdata[0];
                REG_INSTALLED:  installed_reg  <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_NEAR_LEFT:  prdata = DATA_W'(near_left_reg);
            REG_FAR_LEFT:   prdata = DATA_W'(far_left_reg);
            REG_NEAR_FRONT: prdata = DATA_W'(near_front_reg);
            REG_FAR_FRONT:  prdata = DATA_W'(far_front_reg);
            REG_POWER_REQ:  prdata = DATA_W'(power_req_reg);
            REG_INSTALLED:  prdata = DATA_W'(installed_reg);
            default:        prdata = '0;
        endcase
    end

    assign sensor_in.ready = (state_reg == T_IDLE);
    assign accept          = sensor_in.valid && sensor_in.ready;

    always_comb
    begin
        req_left.start    = accept;
        req_left.powered  = powered;
        req_left.raw      = sensor_in.raw_left;
        req_left.near     = near_left_reg;
        req_left.far      = far_left_reg;
        req_front.start   = accept;
        req_front.powered = powered;
        req_front.raw     = sensor_in.raw_front;
        req_front.near    = near_front_reg;
        req_front.far     = far_front_reg;
    end

    irdl_lane u_lane_left (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_left),
        .ack   (load),
        .stat  (stat_left)
    );

    irdl_lane u_lane_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_front),
        .ack   (load),
        .stat  (stat_front)
    );

    // merge both lanes into the result register once it is free
    assign load = (state_reg == T_BUSY) && stat_left.done && stat_front.done
                  && (!out_valid_reg || dist_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                T_IDLE:  if (accept) state_reg <= T_BUSY;
                T_BUSY:  if (load) state_reg <= T_IDLE;
                default: state_reg <= T_IDLE;
            endcase
            if (load)
                out_valid_reg <= 1'b1;
            else if (dist_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dist_left_reg   <= stat_left.distance;
            dist_front_reg  <= stat_front.distance;
            fault_left_reg  <= stat_left.fault;
            fault_front_reg <= stat_front.fault;
        end
    end

    assign dist_out.valid          = out_valid_reg;
    assign dist_out.distance_left  = dist_left_reg;
    assign dist_out.distance_front = dist_front_reg;
    assign dist_out.fault_left     = fault_left_reg;
    assign dist_out.fault_front    = fault_front_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ((state_reg == T_BUSY) && !sensor_in.ready))
        else $error("sample accepted but block did not go busy");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (dist_out.valid && (state_reg == T_IDLE)))
        else $error("merged result not presented");

    a_idle_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_IDLE) |-> (!stat_left.done && !stat_front.done))
        else $error("lane left holding a result while block is idle");

endmodule

FILE: test/ir_distance_linearizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_distance_linearizer_tb
// Self-checking bench for the two-channel IR distance linearizer. A table of
// directed samples covers power off, missing sensors, calibration faults,
// zero readings and saturation. Random phases with fresh calibration follow,
// with sender gaps, receiver stalls and one long receiver hold-off. Every
// result is checked against a typed row or an in-bench inverse-law predictor.
// ----------------------------------------------------------------------------
module ir_distance_linearizer_tb;
    import irdl_pkg::*;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int HOLD_OFF_CYCLES = 800;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 150;
    localparam int PHASES          = 10;
    localparam int PHASE_ITEMS     = 48;
    localparam int PRESSURE_PHASE  = 4;

    localparam logic signed [DIST_W-1:0] DIST_MAX = 24'sh7FFFFF;
    localparam logic signed [DIST_W-1:0] DIST_MIN = 24'sh800000;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance_left;
        logic signed [DIST_W-1:0] distance_front;
        logic                     fault_left;
        logic                     fault_front;
    } distance_result_t;

    typedef struct packed {
        logic [CAL_W-1:0] near_left;
        logic [CAL_W-1:0] far_left;
        logic [CAL_W-1:0] near_front;
        logic [CAL_W-1:0] far_front;
        logic             power_on;
        logic             fitted;
        logic [RAW_W-1:0] raw_left;
        logic [RAW_W-1:0] raw_front;
        logic             typed;
        distance_result_t result;
    } sample_row_t;

    localparam distance_result_t FAR_OK    = '{FAR_DIST, FAR_DIST, 1'b0, 1'b0};
    localparam distance_result_t FAR_FAULT = '{FAR_DIST, FAR_DIST, 1'b1, 1'b1};
    localparam distance_result_t SAT_HIGH  = '{DIST_MAX, DIST_MAX, 1'b0, 1'b0};
    localparam distance_result_t SAT_LOW   = '{DIST_MIN, DIST_MIN, 1'b0, 1'b0};
    localparam distance_result_t NO_TYPED  = '0;

    localparam int DIRECTED_ROWS = 21;

    // near_l, far_l, near_f, far_f, power, fitted, raw_l, raw_f, typed, result
    sample_row_t directed_samples [DIRECTED_ROWS] = '{
        '{16'd3000, 16'd850, 16'd3000, 16'd850, 1'b0, 1'b1, 16'd1000, 16'd2000, 1'b1, FAR_OK},
        '{16'd3000, 16'd850, 16'd3000, 16'd850, 1'b0, 1'b1, 16'd0, 16'd0, 1'b1, FAR_OK},
        '{16'd3000, 16'd850, 16'd3000, 16'd850, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1, FAR_OK},
        '{16'd3000, 16'd850, 16'd3000, 16'd850, 1'b1, 1'b1, 16'd3000, 16'd850, 1'b0, NO_TYPED},
        '{16'd3000, 16'd850, 16'd3000, 16'd850, 1'b1, 1'b1, 16'd1, 16'd1, 1'b0, NO_TYPED},
        '{16'd3000, 16'd850, 16'd3000, 16'd850, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0, NO_TYPED},
        '{16'd3000, 16'd850, 16'd3000, 16'd850, 1'b1, 1'b1, 16'd0, 16'd1234, 1'b0, NO_TYPED},
        '{16'd3000, 16'd850, 16'd3000, 16'd850, 1'b1, 1'b1, 16'h5555, 16'hAAAA, 1'b0, NO_TYPED},
        '{16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFE, 1'b1, 1'b1, 16'd1, 16'd1, 1'b1, SAT_HIGH},
        '{16'hFFFE, 16'hFFFF, 16'hFFFE, 16'hFFFF, 1'b1, 1'b1, 16'd1, 16'd1, 1'b1, SAT_LOW},
        '{16'hFFFE, 16'hFFFF, 16'hFFFE, 16'hFFFF, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1, SAT_LOW},
        '{16'd1000, 16'd1000, 16'd3000, 16'd850, 1'b1, 1'b1, 16'd500, 16'd500, 1'b0, NO_TYPED},
        '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'd1, 16'd1, 1'b1, FAR_FAULT},
        '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 16'd1, 16'd1, 1'b1, FAR_FAULT},
        '{16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 1'b1, 1'b1, 16'd7, 16'd7, 1'b0, NO_TYPED},
        '{16'd3000, 16'd850, 16'd3000, 16'd850, 1'b1, 1'b0, 16'd100, 16'd100, 1'b1, FAR_OK},
        '{16'd3000, 16'd850, 16'd3000, 16'd850, 1'b0, 1'b0, 16'd100, 16'd100, 1'b1, FAR_OK},
        '{16'd3000, 16'd850, 16'd3000, 16'd850, 1'b1, 1'b1, 16'd0, 16'd0, 1'b1, FAR_OK},
        '{16'd3000, 16'd850, 16'd3000, 16'd850, 1'b1, 1'b1, 16'hFFFF, 16'h8000, 1'b0, NO_TYPED},
        '{16'd1200, 16'd1000, 16'd1200, 16'd1000, 1'b1, 1'b1, 16'd2, 16'd2, 1'b0, NO_TYPED},
        '{16'd1200, 16'd1000, 16'd1200, 16'd1000, 1'b1, 1'b1, 16'd1, 16'hFFFE, 1'b0, NO_TYPED}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    irdl_in_if  sensor_if ();
    irdl_out_if dist_if ();

    // predictor copy of the configuration and the held distances
    logic [CAL_W-1:0]         near_cal [2];
    logic [CAL_W-1:0]         far_cal [2];
    logic                     power_req;
    logic                     installed;
    logic signed [DIST_W-1:0] held_dist [2];

    distance_result_t expected_results [$];

    int   error_count = 0;
    int   cycle_count = 0;
    int   sender_idle_pct = 0;
    int   receiver_stall_pct = 0;
    logic hold_off = 1'b0;
    event hold_off_go;

    ir_distance_linearizer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sensor_in (sensor_if),
        .dist_out  (dist_if),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // d = A + B/raw, all divisions truncating toward zero, clamped to 24 bits
    function automatic logic signed [DIST_W-1:0] lane_distance(logic [CAL_W-1:0] n,
                                                               logic [CAL_W-1:0] f,
                                                               logic [RAW_W-1:0] raw);
        longint sn;
        longint sf;
        longint sraw;
        longint den;
        longint aq;
        longint bq;
        longint sum;
        sn   = longint'(n);
        sf   = longint'(f);
        sraw = longint'(raw);
        den  = 5 * (sn - sf);
        aq   = ((sn - 4 * sf) * 65536) / den;
        bq   = (3 * 65536 * (sn * sf)) / den;
        sum  = aq + bq / sraw;
        if (sum > longint'(DIST_MAX))
            return DIST_MAX;
        if (sum < longint'(DIST_MIN))
            return DIST_MIN;
        return DIST_W'(sum);
    endfunction

    function automatic distance_result_t predict_distances(logic [RAW_W-1:0] raw_left,
                                                           logic [RAW_W-1:0] raw_front);
        distance_result_t r;
        logic [RAW_W-1:0] raw [2];
        logic             lane_fault [2];
        logic             powered;
        raw[0]  = raw_left;
        raw[1]  = raw_front;
        powered = power_req && installed;
        for (int ch = 0; ch < 2; ch++)
        begin
            lane_fault[ch] = (near_cal[ch] == far_cal[ch]);
            if (!powered || lane_fault[ch])
                held_dist[ch] = FAR_DIST;
            else if (raw[ch] != '0)
                held_dist[ch] = lane_distance(near_cal[ch], far_cal[ch], raw[ch]);
        end
        r.distance_left  = held_dist[0];
        r.distance_front = held_dist[1];
        r.fault_left     = lane_fault[0];
        r.fault_front    = lane_fault[1];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    task automatic check_distance_result();
        distance_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("distance result with no sample pending");
            return;
        end
        want = expected_results.pop_front();
        if (dist_if.distance_left !== want.distance_left)
            report_mismatch($sformatf("distance_left got %0d, expected %0d",
                                      dist_if.distance_left, want.distance_left));
        if (dist_if.distance_front !== want.distance_front)
            report_mismatch($sformatf("distance_front got %0d, expected %0d",
                                      dist_if.distance_front, want.distance_front));
        if (dist_if.fault_left !== want.fault_left)
            report_mismatch($sformatf("fault_left got %b, expected %b",
                                      dist_if.fault_left, want.fault_left));
        if (dist_if.fault_front !== want.fault_front)
            report_mismatch($sformatf("fault_front got %b, expected %b",
                                      dist_if.fault_front, want.fault_front));
    endtask

    // result side: check each transaction, then pick ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && dist_if.valid && dist_if.ready)
            check_distance_result();
        dist_if.ready <= !hold_off && ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // long receiver hold-off, so the block fills up and stalls its input
    initial
    begin
        @(hold_off_go);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ir_distance_linearizer test failed");
            $finish;
        end
    end

    task automatic write_register(input cfg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_NEAR_LEFT:  near_cal[0] = value[CAL_W-1:0];
            REG_FAR_LEFT:   far_cal[0]  = value[CAL_W-1:0];
            REG_NEAR_FRONT: near_cal[1] = value[CAL_W-1:0];
            REG_FAR_FRONT:  far_cal[1]  = value[CAL_W-1:0];
            REG_POWER_REQ:  power_req   = value[0];
            REG_INSTALLED:  installed   = value[0];
            default: ;
        endcase
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== value)
            report_mismatch($sformatf("register %s read %0h, expected %0h",
                                      idx.name(), prdata, value));
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // leave the bus idle before the next access
        @(posedge clk);
    endtask

    task automatic wait_until_idle();
        sensor_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_config(input logic [CAL_W-1:0] near_left, input logic [CAL_W-1:0] far_left,
                                input logic [CAL_W-1:0] near_front,
                                input logic [CAL_W-1:0] far_front,
                                input logic power_on, input logic fitted);
        if (near_left == near_cal[0] && far_left == far_cal[0] && near_front == near_cal[1]
            && far_front == far_cal[1] && power_on == power_req && fitted == installed)
            return;
        wait_until_idle();
        if (near_left != near_cal[0])
            write_register(REG_NEAR_LEFT, DATA_W'(near_left));
        if (far_left != far_cal[0])
            write_register(REG_FAR_LEFT, DATA_W'(far_left));
        if (near_front != near_cal[1])
            write_register(REG_NEAR_FRONT, DATA_W'(near_front));
        if (far_front != far_cal[1])
            write_register(REG_FAR_FRONT, DATA_W'(far_front));
        if (power_on != power_req)
            write_register(REG_POWER_REQ, DATA_W'(power_on));
        if (fitted != installed)
            write_register(REG_INSTALLED, DATA_W'(fitted));
    endtask

    task automatic send_sample(input logic [RAW_W-1:0] raw_left, input logic [RAW_W-1:0] raw_front,
                               input logic typed, input distance_result_t typed_result);
        distance_result_t predicted;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            sensor_if.valid <= 1'b0;
            @(posedge clk);
        end
        sensor_if.valid     <= 1'b1;
        sensor_if.raw_left  <= raw_left;
        sensor_if.raw_front <= raw_front;
        do
            @(posedge clk);
        while (!sensor_if.ready);
        // advance the predictor even where the result is typed in the table
        predicted = predict_distances(raw_left, raw_front);
        expected_results.push_back(typed ? typed_result : predicted);
    endtask

    function automatic logic [RAW_W-1:0] random_raw();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return RAW_W'($urandom_range(1, 15));
            2:       return RAW_W'(16'hFFFF - 16'($urandom_range(0, 15)));
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic void pick_calibration(output logic [CAL_W-1:0] n,
                                             output logic [CAL_W-1:0] f);
        logic [CAL_W-1:0] a;
        logic [CAL_W-1:0] b;
        a = CAL_W'($urandom);
        case ($urandom_range(0, 9))
            0: b = a;
            1: begin
                b = a;
                a = ($urandom_range(0, 1) != 0) ? '1 : '0;
            end
            2: b = a ^ CAL_W'(1);
            3: b = CAL_W'($urandom);
            default: begin
                b = CAL_W'($urandom_range(100, 2000));
                a = b + CAL_W'($urandom_range(1, 3000));
            end
        endcase
        // swap now and then so extremes land on the far point too
        if ($urandom_range(0, 3) == 0)
        begin
            n = b;
            f = a;
        end
        else
        begin
            n = a;
            f = b;
        end
    endfunction

    initial
    begin
        logic [CAL_W-1:0] n_left;
        logic [CAL_W-1:0] f_left;
        logic [CAL_W-1:0] n_front;
        logic [CAL_W-1:0] f_front;

        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        sensor_if.valid     = 1'b0;
        sensor_if.raw_left  = '0;
        sensor_if.raw_front = '0;
        dist_if.ready       = 1'b0;
        near_cal[0]         = NEAR_RESET;
        near_cal[1]         = NEAR_RESET;
        far_cal[0]          = FAR_RESET;
        far_cal[1]          = FAR_RESET;
        power_req           = 1'b0;
        installed           = 1'b1;
        held_dist[0]        = '0;
        held_dist[1]        = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_samples[i])
        begin
            apply_config(directed_samples[i].near_left, directed_samples[i].far_left,
                         directed_samples[i].near_front, directed_samples[i].far_front,
                         directed_samples[i].power_on, directed_samples[i].fitted);
            send_sample(directed_samples[i].raw_left, directed_samples[i].raw_front,
                        directed_samples[i].typed, directed_samples[i].result);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            pick_calibration(n_left, f_left);
            pick_calibration(n_front, f_front);
            apply_config(n_left, f_left, n_front, f_front,
                         $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0);
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 54; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 54; end
                default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
            endcase
            if (phase == PRESSURE_PHASE)
                -> hold_off_go;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_sample(random_raw(), random_raw(), 1'b0, NO_TYPED);
        end

        sensor_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("ir_distance_linearizer test passed");
        else
            $display("ir_distance_linearizer test failed");
        $finish;
    end

endmodule
